// ===== sv/elu_pkg.sv =====
// elu_pkg.sv: shared widths, mode codes, control struct and log2 table generator
// for the elementwise loss unit. No dependencies; used by elementwise_loss_unit_core.
package elu_pkg;

    // Default table resolution (index bits of the log2 table)
    localparam int unsigned LOG_TABLE_BITS_DEF = 8;

    // Field and datapath widths
    localparam int unsigned FRAC_W   = 16;  // Q0.16 prediction / target
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned LOSS_W   = 32;  // Q16.16 result
    localparam int unsigned LOG_FRAC = 30;  // log2 table fraction bits
    localparam int unsigned LOG_W    = LOG_FRAC + 1;  // entries go up to exactly 1.0
    localparam int unsigned SHIFT_W  = 5;   // normalize shift 0..16
    localparam int unsigned LN2_W    = 30;
    localparam int unsigned NL_W     = 36;  // -ln in Q.32, max ~11.1
    localparam int unsigned BCE_W    = 20;  // |B| in Q16.16, max ~11.1

    localparam logic [LN2_W-1:0]  LN2_Q30  = 30'd744261118;
    localparam logic [LOSS_W-1:0] LOSS_MIN = 32'h8000_0000;

    typedef enum logic [MODE_W-1:0] {
        MODE_DIFF      = 3'd0,
        MODE_LOG       = 3'd1,
        MODE_LOG_CUBE  = 3'd2,
        MODE_DIFF_CUBE = 3'd3,
        MODE_SUM_CUBE  = 3'd4
    } loss_mode_t;

    // Per-transaction control carried alongside the datapath
    typedef struct packed {
        loss_mode_t mode;
        logic       last;
        logic       lt;       // prediction < target
        logic       eq;       // prediction == target
        logic       diverge;  // prediction zero, target nonzero
    } elu_ctl_t;

    // log2(1 + k/2^bits) in Q0.30 by repeated squaring; the end entry is 1.0
    function automatic logic [LOG_W-1:0] log2_entry(input int unsigned k,
                                                    input int unsigned bits);
        logic [63:0]      y;
        logic [LOG_W-1:0] r;
        int               i;
        r = '0;
        y = '0;
        if (k >= (32'd1 << bits)) begin
            r = LOG_W'(64'd1 << LOG_FRAC);
        end
        else begin
            y = (64'd1 << LOG_FRAC) + (64'(k) << (LOG_FRAC - bits));
            for (i = 1; i <= LOG_FRAC; i++) begin
                y = (y * y) >> LOG_FRAC;
                if (y >= (64'd2 << LOG_FRAC)) begin
                    y = y >> 1;
                    r[LOG_FRAC - i] = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/elementwise_loss_unit_core.sv =====
// elementwise_loss_unit_core.sv: pipelined per-element loss term (difference,
// signed cross-entropy, cubes). Depends on elu_pkg (sv/elu_pkg.sv).
//
// The unit takes one prediction/target pair per clock, unless every stage is full
// and the output is stalled, and returns one signed Q16.16 loss term per pair, in
// order. Each result passes through the pipeline stages in this order: input
// register, log normalize, log2 table read, interpolation multiply, ln2 scaling
// multiply, rounding, target weighting multiply, sum, square, cube, mode select and output
// register. Each stage holds its own valid bit and only stalls when every stage
// below it is full, so bubbles are squeezed out and a waiting result does not block
// new transactions while any stage is empty. The log2 table has
// 2^LOG_TABLE_BITS entry pairs, is constant and read at two addresses per cycle
// (one per log lane); there is no start-up fill. loss_mode must be written only
// while no transaction is in flight; modes 5..7 act as mode 0. A prediction of
// zero with a nonzero target saturates the log-based modes to the most negative
// value and sets saturated.
module elementwise_loss_unit_core #(
    parameter int unsigned LOG_TABLE_BITS = elu_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [elu_pkg::MODE_W-1:0]        cfg_wr_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [elu_pkg::FRAC_W-1:0]        prediction,
    input  logic [elu_pkg::FRAC_W-1:0]        target,
    input  logic                              element_last,
    // output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [elu_pkg::LOSS_W-1:0] loss_term,
    output logic                              saturated,
    output logic                              result_last
);

    localparam int unsigned FW       = elu_pkg::FRAC_W;
    localparam int unsigned XW       = FW + 1;
    localparam int unsigned XSW      = 2 * FW + 1;
    localparam int unsigned TBL_DEPTH = 2 ** LOG_TABLE_BITS;
    localparam int unsigned REM_W    = FW - LOG_TABLE_BITS;
    localparam int unsigned LOG_W    = elu_pkg::LOG_W;
    localparam int unsigned SHIFT_W  = elu_pkg::SHIFT_W;
    localparam int unsigned LN2_W    = elu_pkg::LN2_W;
    localparam int unsigned NL_W     = elu_pkg::NL_W;
    localparam int unsigned BCE_W    = elu_pkg::BCE_W;
    localparam int unsigned LOSS_W   = elu_pkg::LOSS_W;
    localparam int unsigned INTERP_W = LOG_W + REM_W;
    localparam int unsigned PV_W     = LOG_W + LN2_W;
    localparam int unsigned KL_W     = SHIFT_W + LN2_W;
    localparam int unsigned NEG_W    = KL_W + elu_pkg::LOG_FRAC;
    localparam int unsigned NL_SH    = 2 * elu_pkg::LOG_FRAC - 32;
    localparam int unsigned MA_W     = XW + NL_W;
    localparam int unsigned MB_W     = FW + NL_W;
    localparam int unsigned ACC_W    = MA_W + 1;
    localparam int unsigned Q_SH     = 2 * FW;   // Q.48 -> Q16.16 and cube rescale
    localparam int unsigned SS_W     = 2 * BCE_W;
    localparam int unsigned CS_W     = 3 * BCE_W;
    localparam int unsigned SD_W     = 2 * FW;
    localparam int unsigned CD_W     = 3 * FW;
    localparam int unsigned CSR_W    = CS_W - Q_SH + 1;
    localparam int unsigned CDR_W    = CD_W - Q_SH + 1;
    localparam int unsigned MAGO_W   = LOSS_W - 1;
    localparam int unsigned NUM_STG  = 12;
    localparam int unsigned LANES    = 2;
    localparam int unsigned LANE_A   = 0;   // -ln(1 - p)
    localparam int unsigned LANE_B   = 1;   // -ln(p)

    localparam logic [XW-1:0]    UNIT    = XW'(32'd1 << FW);
    localparam logic [elu_pkg::LOG_FRAC-1:0] NL_RND = 30'h0800_0000;
    localparam logic [ACC_W-1:0] ACC_RND = ACC_W'(64'd1 << (Q_SH - 1));

    // leading-one normalize: shift that moves the top set bit to bit FW
    function automatic logic [SHIFT_W-1:0] norm_shift(input logic [XW-1:0] x);
        logic [SHIFT_W-1:0] s;
        int                 b;
        s = '0;
        for (b = 0; b < XW; b++) begin
            if (x[b]) begin
                s = SHIFT_W'(FW - b);
            end
        end
        return s;
    endfunction

    // configuration register
    logic [elu_pkg::MODE_W-1:0] loss_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            loss_mode_reg <= '0;
        end
        else if (cfg_wr_en) begin
            loss_mode_reg <= cfg_wr_data;
        end
    end

    // pipeline flow control: a stage loads when the output is ready or when it or any stage below is empty
    logic [NUM_STG:1] vld_reg;
    logic [NUM_STG:1] vld_in;
    logic [NUM_STG:1] stg_ld;

    assign vld_in = {vld_reg[NUM_STG-1:1], in_valid};

    for (genvar g = 1; g <= NUM_STG; g++) begin : g_ld
        assign stg_ld[g] = out_ready || !(&vld_reg[NUM_STG:g]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            for (int i = 1; i <= NUM_STG; i++) begin
                if (stg_ld[i]) begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    assign in_ready  = stg_ld[1];
    assign out_valid = vld_reg[NUM_STG];

    // log2 table: entry k holds {log2 at k+1, log2 at k}
    logic [2*LOG_W-1:0] log_rom [TBL_DEPTH];

    for (genvar g = 0; g < TBL_DEPTH; g++) begin : g_rom
        assign log_rom[g] = {elu_pkg::log2_entry(g + 1, LOG_TABLE_BITS),
                             elu_pkg::log2_entry(g, LOG_TABLE_BITS)};
    end

    // stage 1: input capture
    logic [FW-1:0] s1_pred_reg;
    logic [FW-1:0] s1_tgt_reg;
    logic          s1_last_reg;

    always_ff @(posedge clk)
    begin
        if (stg_ld[1]) begin
            s1_pred_reg <= prediction;
            s1_tgt_reg  <= target;
            s1_last_reg <= element_last;
        end
    end

    // stage 2: compare, difference magnitude, normalize both log arguments
    elu_pkg::elu_ctl_t         ctl_next;
    elu_pkg::elu_ctl_t         ctl_reg [2:NUM_STG-1];
    logic [FW-1:0]             md_next;
    logic [XW-1:0]             s2_x [LANES];
    logic [SHIFT_W-1:0]        s2_k_next [LANES];
    logic [XSW-1:0]            s2_xs [LANES];
    logic [LOG_TABLE_BITS-1:0] s2_idx_reg [LANES];
    logic [REM_W-1:0]          rem_pipe_reg [LANES][2:3];
    logic [SHIFT_W-1:0]        k_pipe_reg [LANES][2:4];
    logic [FW-1:0]             tgt_pipe_reg [2:6];
    logic [XW-1:0]             tgtc_pipe_reg [2:6];
    logic [FW-1:0]             md_pipe_reg [2:10];

    always_comb
    begin
        ctl_next.last    = s1_last_reg;
        ctl_next.lt      = s1_pred_reg < s1_tgt_reg;
        ctl_next.eq      = s1_pred_reg == s1_tgt_reg;
        ctl_next.diverge = (s1_pred_reg == '0) && (s1_tgt_reg != '0);
        case (loss_mode_reg)
            elu_pkg::MODE_LOG:       ctl_next.mode = elu_pkg::MODE_LOG;
            elu_pkg::MODE_LOG_CUBE:  ctl_next.mode = elu_pkg::MODE_LOG_CUBE;
            elu_pkg::MODE_DIFF_CUBE: ctl_next.mode = elu_pkg::MODE_DIFF_CUBE;
            elu_pkg::MODE_SUM_CUBE:  ctl_next.mode = elu_pkg::MODE_SUM_CUBE;
            default:                 ctl_next.mode = elu_pkg::MODE_DIFF;
        endcase
        md_next = ctl_next.lt ? (s1_tgt_reg - s1_pred_reg) : (s1_pred_reg - s1_tgt_reg);
        s2_x[LANE_A] = UNIT - XW'(s1_pred_reg);
        s2_x[LANE_B] = XW'(s1_pred_reg);
        for (int l = 0; l < LANES; l++) begin
            s2_k_next[l] = norm_shift(s2_x[l]);
            s2_xs[l]     = XSW'(s2_x[l]) << s2_k_next[l];
        end
    end

    // stage 2 capture and side pipes: control, target, difference magnitude,
    // shift and remainder
    always_ff @(posedge clk)
    begin
        if (stg_ld[2]) begin
            ctl_reg[2]       <= ctl_next;
            md_pipe_reg[2]   <= md_next;
            tgt_pipe_reg[2]  <= s1_tgt_reg;
            tgtc_pipe_reg[2] <= UNIT - XW'(s1_tgt_reg);
            for (int l = 0; l < LANES; l++) begin
                s2_idx_reg[l]      <= s2_xs[l][FW-1 -: LOG_TABLE_BITS];
                rem_pipe_reg[l][2] <= s2_xs[l][REM_W-1:0];
                k_pipe_reg[l][2]   <= s2_k_next[l];
            end
        end
        for (int i = 3; i <= NUM_STG - 1; i++) begin
            if (stg_ld[i]) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
        for (int i = 3; i <= 6; i++) begin
            if (stg_ld[i]) begin
                tgt_pipe_reg[i]  <= tgt_pipe_reg[i-1];
                tgtc_pipe_reg[i] <= tgtc_pipe_reg[i-1];
            end
        end
        for (int i = 3; i <= 10; i++) begin
            if (stg_ld[i]) begin
                md_pipe_reg[i] <= md_pipe_reg[i-1];
            end
        end
        for (int l = 0; l < LANES; l++) begin
            if (stg_ld[3]) begin
                rem_pipe_reg[l][3] <= rem_pipe_reg[l][2];
                k_pipe_reg[l][3]   <= k_pipe_reg[l][2];
            end
            if (stg_ld[4]) begin
                k_pipe_reg[l][4] <= k_pipe_reg[l][3];
            end
        end
    end

    // stage 3: table read, both lanes
    logic [2*LOG_W-1:0] s3_pair_reg [LANES];

    always_ff @(posedge clk)
    begin
        if (stg_ld[3]) begin
            for (int l = 0; l < LANES; l++) begin
                s3_pair_reg[l] <= log_rom[s2_idx_reg[l]];
            end
        end
    end

    // stage 4: linear interpolation between neighboring entries (truncating)
    logic [LOG_W-1:0]    s4_lo [LANES];
    logic [LOG_W-1:0]    s4_hi [LANES];
    logic [INTERP_W-1:0] s4_prod [LANES];
    logic [LOG_W-1:0]    s4_v_next [LANES];
    logic [LOG_W-1:0]    s4_v_reg [LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++) begin
            s4_lo[l]     = s3_pair_reg[l][LOG_W-1:0];
            s4_hi[l]     = s3_pair_reg[l][2*LOG_W-1:LOG_W];
            s4_prod[l]   = INTERP_W'(s4_hi[l] - s4_lo[l]) * INTERP_W'(rem_pipe_reg[l][3]);
            s4_v_next[l] = s4_lo[l] + LOG_W'(s4_prod[l] >> REM_W);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ld[4]) begin
            s4_v_reg <= s4_v_next;
        end
    end

    // stage 5: scale by ln2; integer part k*ln2 and fraction v*ln2 separately
    logic [PV_W-1:0] s5_pv_reg [LANES];
    logic [KL_W-1:0] s5_kl_reg [LANES];

    always_ff @(posedge clk)
    begin
        if (stg_ld[5]) begin
            for (int l = 0; l < LANES; l++) begin
                s5_pv_reg[l] <= PV_W'(s4_v_reg[l]) * PV_W'(elu_pkg::LN2_Q30);
                s5_kl_reg[l] <= KL_W'(k_pipe_reg[l][4]) * KL_W'(elu_pkg::LN2_Q30);
            end
        end
    end

    // stage 6: -ln in Q.32 = round((k<<30 - v) * ln2 / 2^28), half up
    logic [NEG_W-1:0] s6_neg [LANES];
    logic [NL_W-1:0]  s6_nl_reg [LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++) begin
            s6_neg[l] = {s5_kl_reg[l], NL_RND} - NEG_W'(s5_pv_reg[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ld[6]) begin
            for (int l = 0; l < LANES; l++) begin
                s6_nl_reg[l] <= s6_neg[l][NL_SH +: NL_W];
            end
        end
    end

    // stage 7: weight by (1 - t) and t
    logic [MA_W-1:0] s7_ma_reg;
    logic [MB_W-1:0] s7_mb_reg;

    always_ff @(posedge clk)
    begin
        if (stg_ld[7]) begin
            s7_ma_reg <= MA_W'(tgtc_pipe_reg[6]) * MA_W'(s6_nl_reg[LANE_A]);
            s7_mb_reg <= MB_W'(tgt_pipe_reg[6]) * MB_W'(s6_nl_reg[LANE_B]);
        end
    end

    // stage 8: cross-entropy sum, round to Q16.16; zero when p equals t
    logic [ACC_W-1:0] s8_acc;
    logic [BCE_W-1:0] ms_pipe_reg [8:10];

    assign s8_acc = ACC_W'(s7_ma_reg) + ACC_W'(s7_mb_reg) + ACC_RND;

    always_ff @(posedge clk)
    begin
        if (stg_ld[8]) begin
            ms_pipe_reg[8] <= ctl_reg[7].eq ? '0 : s8_acc[Q_SH +: BCE_W];
        end
        if (stg_ld[9]) begin
            ms_pipe_reg[9] <= ms_pipe_reg[8];
        end
        if (stg_ld[10]) begin
            ms_pipe_reg[10] <= ms_pipe_reg[9];
        end
    end

    // stage 9: squares of both magnitudes
    logic [SS_W-1:0] s9_ss_reg;
    logic [SD_W-1:0] s9_sd_reg;

    always_ff @(posedge clk)
    begin
        if (stg_ld[9]) begin
            s9_ss_reg <= SS_W'(ms_pipe_reg[8]) * SS_W'(ms_pipe_reg[8]);
            s9_sd_reg <= SD_W'(md_pipe_reg[8]) * SD_W'(md_pipe_reg[8]);
        end
    end

    // stage 10: cubes of both magnitudes
    logic [CS_W-1:0] s10_cs_reg;
    logic [CD_W-1:0] s10_cd_reg;

    always_ff @(posedge clk)
    begin
        if (stg_ld[10]) begin
            s10_cs_reg <= CS_W'(s9_ss_reg) * CS_W'(ms_pipe_reg[9]);
            s10_cd_reg <= CD_W'(s9_sd_reg) * CD_W'(md_pipe_reg[9]);
        end
    end

    // stage 11: rescale cubes (round half away on magnitude), pick by mode
    logic [CSR_W-1:0]  s11_cs_r;
    logic [CDR_W-1:0]  s11_cd_r;
    logic [MAGO_W-1:0] s11_mag_next;
    logic [MAGO_W-1:0] s11_mag_reg;

    always_comb
    begin
        s11_cs_r = CSR_W'(s10_cs_reg[CS_W-1:Q_SH]) + CSR_W'(s10_cs_reg[Q_SH-1]);
        s11_cd_r = CDR_W'(s10_cd_reg[CD_W-1:Q_SH]) + CDR_W'(s10_cd_reg[Q_SH-1]);
        case (ctl_reg[10].mode)
            elu_pkg::MODE_LOG:       s11_mag_next = MAGO_W'(ms_pipe_reg[10]);
            elu_pkg::MODE_LOG_CUBE:  s11_mag_next = MAGO_W'(s11_cs_r);
            elu_pkg::MODE_DIFF_CUBE: s11_mag_next = MAGO_W'(s11_cd_r);
            elu_pkg::MODE_SUM_CUBE:  s11_mag_next = MAGO_W'(s11_cs_r) + MAGO_W'(s11_cd_r);
            default:                 s11_mag_next = MAGO_W'(md_pipe_reg[10]);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stg_ld[11]) begin
            s11_mag_reg <= s11_mag_next;
        end
    end

    // stage 12: apply sign (all terms share sign of p - t), divergence override
    logic              sat_next;
    logic [LOSS_W-1:0] loss_next;
    logic [LOSS_W-1:0] loss_term_reg;
    logic              saturated_reg;
    logic              result_last_reg;

    always_comb
    begin
        sat_next = ctl_reg[11].diverge &&
                   (ctl_reg[11].mode inside {elu_pkg::MODE_LOG, elu_pkg::MODE_LOG_CUBE,
                                             elu_pkg::MODE_SUM_CUBE});
        if (sat_next) begin
            loss_next = elu_pkg::LOSS_MIN;
        end
        else if (ctl_reg[11].lt) begin
            loss_next = LOSS_W'(0) - LOSS_W'(s11_mag_reg);
        end
        else begin
            loss_next = LOSS_W'(s11_mag_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ld[NUM_STG]) begin
            loss_term_reg   <= loss_next;
            saturated_reg   <= sat_next;
            result_last_reg <= ctl_reg[11].last;
        end
    end

    assign loss_term   = loss_term_reg;
    assign saturated   = saturated_reg;
    assign result_last = result_last_reg;

    // checks
    a_sat_is_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> loss_term == elu_pkg::LOSS_MIN)
        else $error("saturated result is not the minimum value");

    a_min_only_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !saturated |-> loss_term != elu_pkg::LOSS_MIN)
        else $error("unsaturated result reached the minimum value");

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[NUM_STG] |-> in_ready)
        else $error("input stalled with an empty output register");

    a_out_from_upstream: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(vld_reg[NUM_STG]) |-> $past(vld_reg[NUM_STG-1]))
        else $error("output became valid without an upstream transaction");

    a_cmp_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> !(ctl_reg[2].lt && ctl_reg[2].eq))
        else $error("less-than and equal flags both set");

endmodule

// ===== verif/elu_loss_checker.sv =====
// elu_loss_checker.sv: watches both channels of elementwise_loss_unit_core, predicts each
// loss term from its own fixed-point model and compares in order.
// Depends on elu_pkg (mode codes, widths).
`timescale 1ns / 1ps

module elu_loss_checker #(
    parameter int unsigned TABLE_BITS = elu_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [elu_pkg::MODE_W-1:0]        cfg_wr_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [elu_pkg::FRAC_W-1:0]        prediction,
    input  logic [elu_pkg::FRAC_W-1:0]        target,
    input  logic                              element_last,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [elu_pkg::LOSS_W-1:0] loss_term,
    input  logic                              saturated,
    input  logic                              result_last,
    output int                                fail_count,
    output int                                expected_pending,
    output int                                result_count,
    output int                                saturated_count
);
    import elu_pkg::*;

    localparam int unsigned   INTERP_BITS = FRAC_W - TABLE_BITS;
    localparam logic [63:0]   LN2_SCALE   = 64'd744261118;  // ln2 in Q.30
    localparam logic [63:0]   Q30_ONE     = 64'd1 << 30;
    localparam longint        TERM_MAX    = 64'sd2147483647;
    localparam longint        TERM_MIN    = -64'sd2147483648;
    localparam int            MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [LOSS_W-1:0] loss;
        logic                     sat;
        logic                     last;
    } loss_expect_t;

    logic [63:0]        log2_q30 [0:(1 << TABLE_BITS)];
    loss_expect_t       expect_q [$];
    logic [MODE_W-1:0]  mode_reg;
    int                 n_fail;
    int                 n_reports;
    int                 n_results;
    int                 n_sat;

    // log2 of (1 + k/2^TABLE_BITS) in Q0.30 by square-and-compare, truncating
    function automatic logic [63:0] log2_one_plus(input int unsigned k);
        logic [63:0] y;
        logic [63:0] r;
        int          i;
        r = '0;
        y = Q30_ONE + (64'(k) << (30 - TABLE_BITS));
        for (i = 1; i <= 30; i++) begin
            y = (y * y) >> 30;
            if (y >= 2 * Q30_ONE) begin
                y = y >> 1;
                r = r | (64'd1 << (30 - i));
            end
        end
        return r;
    endfunction

    // -ln(x/65536) in Q.32, x in 1..65536
    function automatic logic [63:0] neg_ln_q32(input logic [FRAC_W:0] x);
        int          e;
        logic [31:0] f;
        logic [31:0] idx;
        logic [63:0] rem;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] v;
        logic [63:0] neg;
        e = FRAC_W;
        while (e > 0 && x[e] == 1'b0)
            e--;
        f   = (32'(x) << (FRAC_W - e)) - 32'h1_0000;
        idx = f >> INTERP_BITS;
        rem = 64'(f & ((32'd1 << INTERP_BITS) - 1));
        lo  = log2_q30[idx];
        hi  = log2_q30[idx + 1];
        v   = lo;
        if (hi > lo)
            v = v + (((hi - lo) * rem) >> INTERP_BITS);
        neg = (64'(FRAC_W - e) << 30) - v;
        return (neg * LN2_SCALE + (64'd1 << 27)) >> 28;
    endfunction

    // Q16.16 cube, rounded half away from zero
    function automatic longint cube_q16(input longint v);
        logic [63:0] m;
        logic [63:0] c;
        m = (v < 0) ? 64'(-v) : 64'(v);
        c = (m * m * m + (64'd1 << 31)) >> 32;
        return (v < 0) ? -longint'(c) : longint'(c);
    endfunction

    function automatic loss_expect_t predict_loss(input logic [FRAC_W-1:0] p,
                                                  input logic [FRAC_W-1:0] t,
                                                  input logic              l,
                                                  input logic [MODE_W-1:0] raw_mode);
        loss_expect_t r;
        loss_mode_t   mode;
        logic         diverge;
        logic [63:0]  acc;
        longint       bce;
        longint       d;
        longint       slog;
        longint       val;
        d       = longint'(p) - longint'(t);
        diverge = (p == '0) && (t != '0);
        mode    = (raw_mode > MODE_SUM_CUBE) ? MODE_DIFF : loss_mode_t'(raw_mode);
        slog    = 0;
        r.sat   = 1'b0;
        r.last  = l;

        // signed cross-entropy term, needed by the log-based modes only
        if (!diverge && (mode == MODE_LOG || mode == MODE_LOG_CUBE || mode == MODE_SUM_CUBE)) begin
            acc = 64'(17'h1_0000 - {1'b0, t}) * neg_ln_q32(17'h1_0000 - {1'b0, p});
            if (t != '0)
                acc = acc + 64'(t) * neg_ln_q32({1'b0, p});
            bce  = longint'((acc + (64'd1 << 31)) >> 32);
            slog = (p > t) ? bce : (p < t) ? -bce : 0;
        end

        case (mode)
            MODE_LOG:       val = slog;
            MODE_LOG_CUBE:  val = cube_q16(slog);
            MODE_DIFF_CUBE: val = cube_q16(d);
            MODE_SUM_CUBE:  val = cube_q16(d) + cube_q16(slog);
            default:        val = d;
        endcase

        // log of zero pins the log-based modes to the floor
        if (diverge && mode != MODE_DIFF && mode != MODE_DIFF_CUBE) begin
            val   = TERM_MIN;
            r.sat = 1'b1;
        end
        if (val > TERM_MAX) begin
            val   = TERM_MAX;
            r.sat = 1'b1;
        end
        else if (val < TERM_MIN) begin
            val   = TERM_MIN;
            r.sat = 1'b1;
        end
        r.loss = val[LOSS_W-1:0];
        return r;
    endfunction

    // constant log2 table and counters
    initial
    begin
        for (int unsigned k = 0; k < (1 << TABLE_BITS); k++)
            log2_q30[k] = log2_one_plus(k);
        log2_q30[1 << TABLE_BITS] = Q30_ONE;
        n_fail           = 0;
        n_reports        = 0;
        n_results        = 0;
        n_sat            = 0;
        mode_reg         = MODE_DIFF;
        fail_count       = 0;
        expected_pending = 0;
        result_count     = 0;
        saturated_count  = 0;
    end

    // channel monitor: compare outputs first, then queue new predictions,
    // then pick up a register write
    always @(posedge clk)
    begin
        loss_expect_t exp_item;
        if (!rst_n) begin
            mode_reg = MODE_DIFF;
        end
        else begin
            if (out_valid && out_ready) begin
                n_results++;
                if (saturated)
                    n_sat++;
                if (expect_q.size() == 0) begin
                    n_fail++;
                    if (n_reports < MAX_REPORTS) begin
                        n_reports++;
                        $display("%0t: unexpected transaction loss_term %0d saturated %0b last %0b",
                                 $time, loss_term, saturated, result_last);
                    end
                end
                else begin
                    exp_item = expect_q.pop_front();
                    if (exp_item.loss !== loss_term || exp_item.sat !== saturated ||
                        exp_item.last !== result_last) begin
                        n_fail++;
                        if (n_reports < MAX_REPORTS) begin
                            n_reports++;
                            $display("%0t: mismatch loss_term exp %0d got %0d, saturated exp %0b got %0b, last exp %0b got %0b",
                                     $time, exp_item.loss, loss_term, exp_item.sat, saturated,
                                     exp_item.last, result_last);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
                expect_q.push_back(predict_loss(prediction, target, element_last, mode_reg));
            if (cfg_wr_en)
                mode_reg = cfg_wr_data;
        end
        fail_count       <= n_fail;
        expected_pending <= expect_q.size();
        result_count     <= n_results;
        saturated_count  <= n_sat;
    end

endmodule

// ===== verif/elementwise_loss_unit_core_tb.sv =====
// elementwise_loss_unit_core_tb.sv: stimulus and verdict for elementwise_loss_unit_core.
// Depends on elu_pkg, elementwise_loss_unit_core and elu_loss_checker.
`timescale 1ns / 1ps

module elementwise_loss_unit_core_tb;
    import elu_pkg::*;

    // codes above the defined modes behave as plain difference
    localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
    localparam int                PHASES       = 15;
    localparam int                MAIN_ITEMS   = 120;
    localparam int                SPARE_ITEMS  = 30;
    localparam int                SETTLE       = 16;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [MODE_W-1:0]          cfg_wr_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [FRAC_W-1:0]          prediction;
    logic [FRAC_W-1:0]          target;
    logic                       element_last;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [LOSS_W-1:0]   loss_term;
    logic                       saturated;
    logic                       result_last;

    int fail_count;
    int expected_pending;
    int result_count;
    int saturated_count;
    int gap_pct   = 0;
    int stall_pct = 0;
    int mode_writes = 0;

    logic [MODE_W-1:0] mode_plan [PHASES] = '{
        MODE_LOG, MODE_LOG_CUBE, MODE_DIFF_CUBE, MODE_SUM_CUBE, MODE_DIFF,
        MODE_SPARE_5, MODE_SPARE_6, MODE_SPARE_7, MODE_SUM_CUBE, MODE_LOG_CUBE,
        MODE_LOG, MODE_DIFF_CUBE, MODE_DIFF, MODE_SUM_CUBE, MODE_LOG
    };

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    elementwise_loss_unit_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .prediction   (prediction),
        .target       (target),
        .element_last (element_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .loss_term    (loss_term),
        .saturated    (saturated),
        .result_last  (result_last)
    );

    elu_loss_checker #(
        .TABLE_BITS (LOG_TABLE_BITS_DEF)
    ) i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .prediction       (prediction),
        .target           (target),
        .element_last     (element_last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .loss_term        (loss_term),
        .saturated        (saturated),
        .result_last      (result_last),
        .fail_count       (fail_count),
        .expected_pending (expected_pending),
        .result_count     (result_count),
        .saturated_count  (saturated_count)
    );

    // receiver backpressure
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    // one transaction, with an optional random gap before valid rises
    task automatic send_item(input logic [FRAC_W-1:0] p, input logic [FRAC_W-1:0] t,
                             input logic l);
        while ($urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        prediction   <= p;
        target       <= t;
        element_last <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // stop sending and wait until every transaction has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_pending != 0)
            @(posedge clk);
    endtask

    task automatic set_mode(input logic [MODE_W-1:0] m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mode_writes++;
    endtask

    // corners, values tied to the other operand, and plain random values
    function automatic logic [FRAC_W-1:0] pick_frac(input logic [FRAC_W-1:0] other);
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return FRAC_W'(1);
            2:       return '1;
            3:       return '1 - FRAC_W'(1);
            4:       return other;
            5:       return other + FRAC_W'($urandom_range(1, 8));
            6:       return other - FRAC_W'($urandom_range(1, 8));
            default: return FRAC_W'($urandom());
        endcase
    endfunction

    initial
    begin
        logic [FRAC_W-1:0] p;
        logic [FRAC_W-1:0] t;
        int                n_items;
        loss_mode_t        dir_mode;
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= MODE_DIFF;
        in_valid     <= 1'b0;
        prediction   <= '0;
        target       <= '0;
        element_last <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: both-zero, log of zero with small and full target,
        // full-scale difference and equal operands, under each of modes 0..4
        dir_mode = MODE_DIFF;
        for (int m = 0; m <= MODE_SUM_CUBE; m++) begin
            drain();
            set_mode(dir_mode);
            send_item('0, '0, 1'b1);
            send_item('0, FRAC_W'(1), 1'b0);
            send_item('0, '1, 1'b1);
            send_item('1, '0, 1'b0);
            send_item(16'h8000, 16'h8000, 1'b1);
            dir_mode = dir_mode.next();
        end

        // random phases, rotating through the idle profiles
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            set_mode(mode_plan[ph]);
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 70; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 70; end
                default: begin gap_pct = 7; stall_pct = 7; end
            endcase
            n_items = (mode_plan[ph] > MODE_SUM_CUBE) ? SPARE_ITEMS : MAIN_ITEMS;
            for (int i = 0; i < n_items; i++) begin
                t = FRAC_W'($urandom());
                p = pick_frac(t);
                if ($urandom_range(0, 3) == 0)
                    t = pick_frac(p);
                send_item(p, t, ($urandom_range(0, 3) == 0));
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        $display("Checked %0d transactions over %0d loss_mode writes (modes 0..7),",
                 result_count, mode_writes);
        $display("%0d saturated terms, under no idling, sender gaps, receiver stalls and both.",
                 saturated_count);
        if (fail_count == 0)
            $display("** elementwise_loss_unit_core: PASSED **");
        else
            $display("** elementwise_loss_unit_core: FAILED **");
        $finish;
    end

    // hang guard
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d transactions outstanding", expected_pending);
        $display("** elementwise_loss_unit_core: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/elu_pkg.sv
sv/elementwise_loss_unit_core.sv
verif/elu_loss_checker.sv
verif/elementwise_loss_unit_core_tb.sv
